// ----- hw/rtl/ccq_pkg.sv -----
package ccq_pkg;

	localparam int SAMPLE_W = 16;
	// Centred components and spans reach +/-65535; they are held in 18 signed bits.
	localparam int GEOM_W   = SAMPLE_W + 2;
	localparam int PROD_W   = 2 * GEOM_W;

	localparam logic [SAMPLE_W-1:0] LOW_RESET  = 16'h7FFF;
	localparam logic [SAMPLE_W-1:0] HIGH_RESET = 16'h8000;

	typedef enum logic [1:0] {
		DIR_NORTH = 2'd0,
		DIR_EAST  = 2'd1,
		DIR_SOUTH = 2'd2,
		DIR_WEST  = 2'd3
	} dir_t;

	typedef enum logic {
		OP_CALIBRATE = 1'b0,
		OP_HEADING   = 1'b1
	} op_t;

	typedef struct packed {
		logic signed [GEOM_W-1:0] ax;
		logic signed [GEOM_W-1:0] ay;
		logic signed [GEOM_W-1:0] span_x;
		logic signed [GEOM_W-1:0] span_y;
		logic                     span_zero;
	} geom_t;

	typedef struct packed {
		logic signed [PROD_W-1:0] px;
		logic signed [PROD_W-1:0] py;
		logic                     span_zero;
	} prod_t;

	// Sector of the vector (px, py), angle counter-clockwise from +x. An angle
	// on a sector edge belongs to the sector that the edge opens.
	function automatic dir_t sector(input logic signed [PROD_W-1:0] px,
			input logic signed [PROD_W-1:0] py);
		logic signed [PROD_W-1:0] npx;
		dir_t                     d;
		npx = -px;
		if (px == '0 && py == '0) begin
			d = DIR_NORTH;
		end else if (py < px && py >= npx) begin
			d = DIR_NORTH;
		end else if (py >= px && py > npx) begin
			d = DIR_EAST;
		end else if (py > px && py <= npx) begin
			d = DIR_SOUTH;
		end else begin
			d = DIR_WEST;
		end
		return d;
	endfunction

endpackage

// ----- hw/rtl/ccq_extremes.sv -----
module ccq_extremes (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                update,
	input  logic signed [ccq_pkg::SAMPLE_W-1:0] sample_x,
	input  logic signed [ccq_pkg::SAMPLE_W-1:0] sample_y,
	output ccq_pkg::geom_t                      geom
);

	logic signed [ccq_pkg::SAMPLE_W-1:0] x_low_q, x_high_q, y_low_q, y_high_q;
	logic signed [ccq_pkg::SAMPLE_W-1:0] x_low, x_high, y_low, y_high;
	logic signed [ccq_pkg::GEOM_W-1:0]   xl_e, xh_e, yl_e, yh_e, sx2, sy2;

	// The sample widens the extremes before its own heading is worked out.
	always_comb begin
		x_low  = (sample_x < x_low_q)  ? sample_x : x_low_q;
		x_high = (sample_x > x_high_q) ? sample_x : x_high_q;
		y_low  = (sample_y < y_low_q)  ? sample_y : y_low_q;
		y_high = (sample_y > y_high_q) ? sample_y : y_high_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_low_q  <= ccq_pkg::LOW_RESET;
			x_high_q <= ccq_pkg::HIGH_RESET;
			y_low_q  <= ccq_pkg::LOW_RESET;
			y_high_q <= ccq_pkg::HIGH_RESET;
		end else if (update) begin
			x_low_q  <= x_low;
			x_high_q <= x_high;
			y_low_q  <= y_low;
			y_high_q <= y_high;
		end
	end

	always_comb begin
		xl_e = {{2{x_low[ccq_pkg::SAMPLE_W-1]}}, x_low};
		xh_e = {{2{x_high[ccq_pkg::SAMPLE_W-1]}}, x_high};
		yl_e = {{2{y_low[ccq_pkg::SAMPLE_W-1]}}, y_low};
		yh_e = {{2{y_high[ccq_pkg::SAMPLE_W-1]}}, y_high};
		sx2  = {sample_x[ccq_pkg::SAMPLE_W-1], sample_x, 1'b0};
		sy2  = {sample_y[ccq_pkg::SAMPLE_W-1], sample_y, 1'b0};
		// 2*(m - low) - (high - low) reduces to 2*m - low - high.
		geom.ax        = sx2 - xl_e - xh_e;
		geom.ay        = sy2 - yl_e - yh_e;
		geom.span_x    = xh_e - xl_e;
		geom.span_y    = yh_e - yl_e;
		geom.span_zero = (x_high == x_low) || (y_high == y_low);
	end

endmodule

// ----- hw/rtl/calibrated_compass_quadrant_core.sv -----
// Calibrated compass quadrant core.
// Input stream (s_*): one transfer per magnetometer sample. s_tdata carries
// sample_x and sample_y; s_tuser selects a calibration sample (0) or a heading
// request (1). Every sample widens the running per-axis minima and maxima.
// Output stream (m_*): one transfer per heading request, in request order,
// giving the compass sector of the centred sample and a flag that is set
// (with direction west) when either axis has a zero calibration span.
// Calibration samples produce no output transfer.
// Path: a request is registered at the input, then the extreme update and
// centring feed the geometry register, two 18x18 multiplies the product
// register, and the sector compare the output register that drives m_tvalid.
// Throughput: one sample per cycle while s_tready is high. When the receiver
// stalls, results hold in the pipeline and input is still taken until every
// stage holds a heading request; s_tready then drops until m_tready returns.
// Reset clears the pipeline and returns the minima to +32767 and the maxima to
// -32768, so the first sample sets both extremes of each axis.
module calibrated_compass_quadrant_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // sample_x [15:0], sample_y [31:16]
	input  logic [0:0]  s_tuser,   // op [0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata    // direction [1:0], span_zero [2], zero fill [7:3]
);

	logic                                valid_s1, valid_s2, valid_s3, out_valid_q;
	ccq_pkg::op_t                        op_s1;
	logic signed [ccq_pkg::SAMPLE_W-1:0] x_s1, y_s1;
	ccq_pkg::geom_t                      geom, geom_s2;
	ccq_pkg::prod_t                      prod_s3;
	ccq_pkg::dir_t                       dir_q;
	logic                                zero_q;
	logic                                out_en, s3_en, s2_en, s1_en;

	always_comb begin
		out_en   = !out_valid_q || m_tready;
		s3_en    = !valid_s3 || out_en;
		s2_en    = !valid_s2 || s3_en;
		// A calibration sample leaves stage one without needing room further on.
		s1_en    = !valid_s1 || (op_s1 == ccq_pkg::OP_CALIBRATE) || s2_en;
		s_tready = s1_en;
	end

	ccq_extremes u_extremes (
		.clk      (clk),
		.arst_n   (arst_n),
		.update   (valid_s1 && s1_en),
		.sample_x (x_s1),
		.sample_y (y_s1),
		.geom     (geom)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_en) begin
				valid_s1 <= s_tvalid;
			end
			if (s2_en) begin
				valid_s2 <= valid_s1 && (op_s1 == ccq_pkg::OP_HEADING);
			end
			if (s3_en) begin
				valid_s3 <= valid_s2;
			end
			if (out_en) begin
				out_valid_q <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_en && s_tvalid) begin
			op_s1 <= ccq_pkg::op_t'(s_tuser[0]);
			x_s1  <= s_tdata[15:0];
			y_s1  <= s_tdata[31:16];
		end
		if (s2_en) begin
			geom_s2 <= geom;
		end
		if (s3_en) begin
			prod_s3.px        <= geom_s2.ax * geom_s2.span_y;
			prod_s3.py        <= geom_s2.ay * geom_s2.span_x;
			prod_s3.span_zero <= geom_s2.span_zero;
		end
		if (out_en) begin
			dir_q  <= prod_s3.span_zero ? ccq_pkg::DIR_WEST
				: ccq_pkg::sector(prod_s3.px, prod_s3.py);
			zero_q <= prod_s3.span_zero;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b0, zero_q, dir_q};

endmodule
